/* src/lssg_pkg.sv */
// Shared types, constants and helper functions for the laser scan speed governor.
`default_nettype none
package lssg_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int TRIM       = 3;

	localparam int DIST_W    = 16;
	localparam int SPEED_W   = 12;
	localparam int FWD_W     = 16;
	localparam int SLOPE_W   = 16;
	localparam int LEN_W     = 11;
	localparam int IDX_W     = $clog2(MAX_POINTS);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam logic [DIST_W-1:0] REPAIR_FLOOR = DIST_W'(200);
	localparam logic [DIST_W-1:0] DIST_MAX     = '1;

	// floor(len / TRIM) as a multiply by a rounded-up reciprocal; exact for len < 2**LEN_W
	localparam int DIV_SH  = LEN_W + $clog2(TRIM);
	localparam int RECIP   = (2**DIV_SH + TRIM - 1) / TRIM;
	localparam int RECIP_W = DIV_SH;
	localparam int PROD_W  = LEN_W + RECIP_W;

	localparam logic [DIST_W-1:0]  STOP_THR_RST   = DIST_W'(650);
	localparam logic [DIST_W-1:0]  SLOW_THR_RST   = DIST_W'(1250);
	localparam logic [SPEED_W-1:0] CRAWL_SPD_RST  = SPEED_W'(0);
	localparam logic [SPEED_W-1:0] CRUISE_SPD_RST = SPEED_W'(700);
	localparam logic [SPEED_W-1:0] RESIDUE_RST    = SPEED_W'(200);
	localparam logic [SLOPE_W-1:0] SLOPE_Q8_RST   = SLOPE_W'(299);
	localparam logic [SPEED_W-1:0] TURN_RATE_RST  = SPEED_W'(800);
	localparam logic [LEN_W-1:0]   SCAN_LEN_RST   = LEN_W'(1024);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STOP_THR   = 3'd0,
		REG_SLOW_THR   = 3'd1,
		REG_CRAWL_SPD  = 3'd2,
		REG_CRUISE_SPD = 3'd3,
		REG_RESIDUE    = 3'd4,
		REG_SLOPE_Q8   = 3'd5,
		REG_TURN_RATE  = 3'd6,
		REG_SCAN_LEN   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [DIST_W-1:0]  stop_thr;
		logic [DIST_W-1:0]  slow_thr;
		logic [SPEED_W-1:0] crawl_spd;
		logic [SPEED_W-1:0] cruise_spd;
		logic [SPEED_W-1:0] residue;
		logic [SLOPE_W-1:0] slope_q8;
		logic [SPEED_W-1:0] turn_rate;
	} drive_cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] last;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
	} bounds_t;

	// Clamp the length and derive last index and middle window.
	function automatic bounds_t scan_bounds(input logic [LEN_W-1:0] len_raw);
		logic [LEN_W-1:0]  len;
		logic [PROD_W-1:0] prod;
		logic [LEN_W-1:0]  lo;
		logic [LEN_W-1:0]  hi;
		bounds_t           b;
		len = len_raw;
		if (len == '0) begin
			len = LEN_W'(1);
		end else if (int'(len) > MAX_POINTS) begin
			len = LEN_W'(MAX_POINTS);
		end
		prod = PROD_W'(len) * PROD_W'(RECIP);
		lo   = LEN_W'(prod >> DIV_SH);
		hi   = len - lo - LEN_W'(1);
		if (hi < lo) begin
			hi = lo;
		end
		b.last = IDX_W'(len - LEN_W'(1));
		b.lo   = IDX_W'(lo);
		b.hi   = IDX_W'(hi);
		return b;
	endfunction

endpackage
`default_nettype wire

/* src/laser_scan_speed_governor.sv */
// Top level: sample repair, middle-window minimum and drive speed output.
// Throughput: one distance sample per cycle while in_ready is high; samples other than the last give no result.
// The minimum for a scan is registered in the stage register and then in the output register before out_valid.
// The minimum is handed over through one stage register, so a stalled output holds one
// result in the output register and one in the stage register before in_ready drops.
// Reset loads the register defaults and starts a fresh scan; no clearing pass.
`default_nettype none
module laser_scan_speed_governor (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [lssg_pkg::DIST_W-1:0]         distance,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [lssg_pkg::FWD_W-1:0]          forward_speed,
	output logic [lssg_pkg::SPEED_W-1:0]        turn_speed,
	output logic [lssg_pkg::DIST_W-1:0]         nearest_distance,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [lssg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [lssg_pkg::CFG_DAT_W-1:0]      cfg_data
);
	import lssg_pkg::*;

	drive_cfg_t        cfg_q;
	bounds_t           bounds_q;
	logic [DIST_W-1:0] prev_q;
	logic [IDX_W-1:0]  idx_q;
	logic [DIST_W-1:0] min_q;
	logic              valid_s1;
	logic [DIST_W-1:0] min_s1;

	logic              in_acc;
	logic              adv_s1;
	logic              calc_ready;
	logic              scan_last;
	logic [DIST_W-1:0] d_rep;
	logic [DIST_W-1:0] min_nxt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_thr   <= STOP_THR_RST;
			cfg_q.slow_thr   <= SLOW_THR_RST;
			cfg_q.crawl_spd  <= CRAWL_SPD_RST;
			cfg_q.cruise_spd <= CRUISE_SPD_RST;
			cfg_q.residue    <= RESIDUE_RST;
			cfg_q.slope_q8   <= SLOPE_Q8_RST;
			cfg_q.turn_rate  <= TURN_RATE_RST;
			bounds_q         <= scan_bounds(SCAN_LEN_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_STOP_THR:   cfg_q.stop_thr   <= cfg_data;
				REG_SLOW_THR:   cfg_q.slow_thr   <= cfg_data;
				REG_CRAWL_SPD:  cfg_q.crawl_spd  <= cfg_data[SPEED_W-1:0];
				REG_CRUISE_SPD: cfg_q.cruise_spd <= cfg_data[SPEED_W-1:0];
				REG_RESIDUE:    cfg_q.residue    <= cfg_data[SPEED_W-1:0];
				REG_SLOPE_Q8:   cfg_q.slope_q8   <= cfg_data;
				REG_TURN_RATE:  cfg_q.turn_rate  <= cfg_data[SPEED_W-1:0];
				REG_SCAN_LEN:   bounds_q         <= scan_bounds(cfg_data[LEN_W-1:0]);
				default: ;
			endcase
		end
	end

	assign adv_s1   = valid_s1 && calc_ready;
	assign in_ready = !valid_s1 || adv_s1;
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		if (distance < REPAIR_FLOOR) begin
			d_rep = (idx_q == '0) ? REPAIR_FLOOR : prev_q;
		end else begin
			d_rep = distance;
		end
		if (idx_q >= bounds_q.lo && idx_q <= bounds_q.hi && d_rep < min_q) begin
			min_nxt = d_rep;
		end else begin
			min_nxt = min_q;
		end
		// a shortened length ends the scan on the current sample
		scan_last = idx_q >= bounds_q.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			idx_q    <= '0;
			min_q    <= DIST_MAX;
			valid_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				if (scan_last) begin
					prev_q <= '0;
					idx_q  <= '0;
					min_q  <= DIST_MAX;
				end else begin
					prev_q <= d_rep;
					idx_q  <= idx_q + IDX_W'(1);
					min_q  <= min_nxt;
				end
			end
			if (in_acc && scan_last) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && scan_last) begin
			min_s1 <= min_nxt;
		end
	end

	lssg_speed_calc u_speed_calc (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.req_valid        (valid_s1),
		.req_ready        (calc_ready),
		.req_min          (min_s1),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.forward_speed    (forward_speed),
		.turn_speed       (turn_speed),
		.nearest_distance (nearest_distance)
	);

endmodule
`default_nettype wire

/* src/lssg_speed_calc.sv */
// Speed rule on the scan minimum, with the result output register.
`default_nettype none
module lssg_speed_calc (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  lssg_pkg::drive_cfg_t                cfg,
	input  wire                                 req_valid,
	output logic                                req_ready,
	input  wire  [lssg_pkg::DIST_W-1:0]         req_min,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [lssg_pkg::FWD_W-1:0]          forward_speed,
	output logic [lssg_pkg::SPEED_W-1:0]        turn_speed,
	output logic [lssg_pkg::DIST_W-1:0]         nearest_distance
);
	import lssg_pkg::*;

	localparam int MUL_W = SLOPE_W + DIST_W;
	localparam int SUM_W = MUL_W - 8 + 1;

	logic [DIST_W-1:0]  gap;
	logic [MUL_W-1:0]   ramp_prod;
	logic [SUM_W-1:0]   ramp_sum;
	logic [FWD_W-1:0]   fwd_nxt;
	logic [SPEED_W-1:0] turn_nxt;
	logic               out_valid_q;
	logic [FWD_W-1:0]   fwd_q;
	logic [SPEED_W-1:0] turn_q;
	logic [DIST_W-1:0]  near_q;

	assign req_ready = !out_valid_q || out_ready;

	always_comb begin
		gap       = req_min - cfg.stop_thr;
		ramp_prod = MUL_W'(cfg.slope_q8) * MUL_W'(gap);
		ramp_sum  = SUM_W'(cfg.crawl_spd) + SUM_W'(cfg.residue) + SUM_W'(ramp_prod >> 8);
		if (req_min < cfg.stop_thr) begin
			fwd_nxt  = FWD_W'(cfg.crawl_spd);
			turn_nxt = cfg.turn_rate;
		end else if (req_min < cfg.slow_thr) begin
			// saturate the ramp at full scale
			fwd_nxt  = (ramp_sum > SUM_W'(DIST_MAX)) ? '1 : FWD_W'(ramp_sum);
			turn_nxt = '0;
		end else begin
			fwd_nxt  = FWD_W'(cfg.cruise_spd);
			turn_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req_ready) begin
			out_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			fwd_q  <= fwd_nxt;
			turn_q <= turn_nxt;
			near_q <= req_min;
		end
	end

	assign out_valid        = out_valid_q;
	assign forward_speed    = fwd_q;
	assign turn_speed       = turn_q;
	assign nearest_distance = near_q;

endmodule
`default_nettype wire

/* src/lssg_checker.sv */
// Port-level assertions for the laser scan speed governor, bound to the top level.
`default_nettype none
module lssg_checker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 out_valid,
	input  wire                                 out_ready,
	input  wire  [lssg_pkg::FWD_W-1:0]          forward_speed,
	input  wire  [lssg_pkg::SPEED_W-1:0]        turn_speed,
	input  wire  [lssg_pkg::DIST_W-1:0]         nearest_distance
);
	import lssg_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(forward_speed)
			&& $stable(turn_speed) && $stable(nearest_distance))
		else $error("result changed while stalled");

	// repaired samples never fall below the floor
	a_near_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> nearest_distance >= REPAIR_FLOOR)
		else $error("nearest distance below repair floor");

	// turning only happens in the stop branch, where forward is the 12-bit min speed
	a_turn_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && turn_speed != '0 |-> forward_speed < FWD_W'(2**SPEED_W))
		else $error("turn with a ramp or saturated forward speed");

endmodule

bind laser_scan_speed_governor lssg_checker u_lssg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.forward_speed    (forward_speed),
	.turn_speed       (turn_speed),
	.nearest_distance (nearest_distance)
);
`default_nettype wire
